// ----- rtl/core/sfx_pkg.sv -----
// Package for the serial frame parser with XOR check.
// Holds the frame constants, the parse phase type and the result record.
// No dependencies; sfx_parse, the top level and the testbench refer to it by scoped name.
package sfx_pkg;

   // Default total frame length in bytes, check byte included.
   localparam int unsigned FRAME_LEN_DEFAULT = 8;

   localparam logic [7:0] HDR_FIRST  = 8'hB4;
   localparam logic [7:0] HDR_SECOND = 8'h69;

   // Frame positions of the second header byte, the command byte and the big-endian value.
   localparam int unsigned HDR_SECOND_INDEX = 1;
   localparam int unsigned CMD_INDEX        = 2;
   localparam int unsigned VALUE_FIRST      = 3;
   localparam int unsigned VALUE_LAST       = 6;

   typedef enum logic [1:0] {
      PH_HUNT  = 2'd0,
      PH_HDR2  = 2'd1,
      PH_BODY  = 2'd2,
      PH_CHECK = 2'd3
   } phase_type;

   typedef struct packed {
      logic               checksum_ok;
      logic [7:0]         command_byte;
      logic signed [31:0] measured_value;
   } result_type;

endpackage

// ----- rtl/core/sfx_req_if.sv -----
// Input channel of the frame parser: one received byte per transaction.
// Standalone; valid/ready handshake with source and sink modports.
interface sfx_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- rtl/core/sfx_rsp_if.sv -----
// Result channel of the frame parser: one frame verdict per transaction.
// Standalone; valid/ready handshake with source and sink modports.
interface sfx_rsp_if;
   logic               valid;
   logic               ready;
   logic               checksum_ok;
   logic [7:0]         command_byte;
   logic signed [31:0] measured_value;

   modport source (output valid, output checksum_ok, output command_byte,
                   output measured_value, input ready);
   modport sink   (input valid, input checksum_ok, input command_byte,
                   input measured_value, output ready);
endinterface

// ----- rtl/core/sfx_parse.sv -----
// Frame parse state machine: header hunt, running XOR and held fields.
// Depends on sfx_pkg for the phase type, constants and result record.
module sfx_parse #(
   parameter int unsigned FRAME_LEN = sfx_pkg::FRAME_LEN_DEFAULT
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          rx_byte,
   output logic                res_valid,
   output sfx_pkg::result_type result
);

   localparam int unsigned IdxW = $clog2(FRAME_LEN);
   localparam logic [IdxW-1:0] IdxHdr2   = IdxW'(sfx_pkg::HDR_SECOND_INDEX);
   localparam logic [IdxW-1:0] IdxCmd    = IdxW'(sfx_pkg::CMD_INDEX);
   localparam logic [IdxW-1:0] IdxValLo  = IdxW'(sfx_pkg::VALUE_FIRST);
   localparam logic [IdxW-1:0] IdxValHi  = IdxW'(sfx_pkg::VALUE_LAST);
   localparam logic [IdxW-1:0] IdxCheck  = IdxW'(FRAME_LEN - 1);

   sfx_pkg::phase_type phase_ff, phase_in;
   logic [IdxW-1:0]    index_ff, index_in;
   logic [7:0]         xor_ff, xor_in;
   logic [7:0]         cmd_ff, cmd_in;
   logic [31:0]        value_ff, value_in;
   logic [IdxW-1:0]    index_inc;

   assign index_inc = index_ff + IdxW'(1);

   // Next state.
   always_comb begin
      phase_in = phase_ff;
      index_in = index_ff;
      xor_in   = xor_ff;
      cmd_in   = cmd_ff;
      value_in = value_ff;
      if (step) begin
         unique case (phase_ff)
            sfx_pkg::PH_HUNT: begin
               if (rx_byte == sfx_pkg::HDR_FIRST) begin
                  xor_in   = rx_byte;
                  index_in = IdxHdr2;
                  phase_in = sfx_pkg::PH_HDR2;
               end
            end
            sfx_pkg::PH_HDR2: begin
               if (rx_byte == sfx_pkg::HDR_SECOND) begin
                  xor_in   = xor_ff ^ rx_byte;
                  index_in = IdxCmd;
                  value_in = '0;
                  phase_in = sfx_pkg::PH_BODY;
               end else begin
                  // The rejected byte is not retried as a first header byte.
                  xor_in   = '0;
                  index_in = '0;
                  phase_in = sfx_pkg::PH_HUNT;
               end
            end
            sfx_pkg::PH_BODY: begin
               if (index_ff == IdxCmd) begin
                  cmd_in = rx_byte;
               end else if (index_ff >= IdxValLo && index_ff <= IdxValHi) begin
                  value_in = {value_ff[23:0], rx_byte};
               end
               xor_in   = xor_ff ^ rx_byte;
               index_in = index_inc;
               if (index_inc == IdxCheck) begin
                  phase_in = sfx_pkg::PH_CHECK;
               end
            end
            sfx_pkg::PH_CHECK: begin
               xor_in   = '0;
               index_in = '0;
               phase_in = sfx_pkg::PH_HUNT;
            end
            default: begin
               phase_in = sfx_pkg::PH_HUNT;
            end
         endcase
      end
   end

   // Outputs: a verdict only when the check byte is consumed.
   always_comb begin
      res_valid             = step && (phase_ff == sfx_pkg::PH_CHECK);
      result.checksum_ok    = (rx_byte == xor_ff);
      result.command_byte   = cmd_ff;
      result.measured_value = result.checksum_ok ? signed'(value_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= sfx_pkg::PH_HUNT;
         index_ff <= '0;
         xor_ff   <= '0;
         cmd_ff   <= '0;
         value_ff <= '0;
      end else begin
         phase_ff <= phase_in;
         index_ff <= index_in;
         xor_ff   <= xor_in;
         cmd_ff   <= cmd_in;
         value_ff <= value_in;
      end
   end

   a_result_ends_frame: assert property (@(posedge clock) disable iff (reset)
      res_valid |=> (phase_ff == sfx_pkg::PH_HUNT) && (index_ff == '0) && (xor_ff == '0))
      else $error("parser did not return to the hunt after a frame");

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      index_ff <= IdxCheck)
      else $error("frame byte index beyond the check byte");

   a_check_index: assert property (@(posedge clock) disable iff (reset)
      (phase_ff == sfx_pkg::PH_CHECK) |-> (index_ff == IdxCheck))
      else $error("check phase reached at the wrong byte index");

   a_failed_value_zero: assert property (@(posedge clock) disable iff (reset)
      (res_valid && !result.checksum_ok) |-> (result.measured_value == '0))
      else $error("value not cleared on a failed checksum");

endmodule

// ----- rtl/core/sensor_frame_parser_xor_check.sv -----
// A check byte sits in the input register, then its verdict in the result register.
// Throughput: one byte per cycle, set by the combinational parse step between the input
// and result registers; a waiting verdict stalls the input once the input register is full.
// Reset: synchronous, active high; clears both valid flags and returns the parser to the
// header hunt with a cleared running XOR, command and value.
// Depends on sfx_pkg, sfx_req_if, sfx_rsp_if and sfx_parse.
module sensor_frame_parser_xor_check #(
   parameter int unsigned FRAME_LEN = sfx_pkg::FRAME_LEN_DEFAULT
) (
   input logic       clock,
   input logic       reset,
   sfx_req_if.sink   req_chan,
   sfx_rsp_if.source rsp_chan
);

   // Input register: one received byte waiting for the parse step.
   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff, in_byte_in;

   // Result register: one finished frame verdict waiting for the consumer.
   logic                rsp_valid_ff, rsp_valid_in;
   sfx_pkg::result_type rsp_data_ff, rsp_data_in;

   logic                advance;
   logic                res_valid;
   sfx_pkg::result_type result;

   // The parse step may run whenever the result register is free or is being
   // emptied in this cycle. A byte that yields no verdict still needs this,
   // which keeps the byte order through the parser simple and strict.
   assign advance        = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = !in_valid_ff || advance;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_chan.ready) begin
         in_valid_in = req_chan.valid;
         in_byte_in  = req_chan.rx_byte;
      end
   end

   sfx_parse #(
      .FRAME_LEN (FRAME_LEN)
   ) u_parse (
      .clock     (clock),
      .reset     (reset),
      .step      (in_valid_ff && advance),
      .rx_byte   (in_byte_ff),
      .res_valid (res_valid),
      .result    (result)
   );

   // When the parse step runs, the result register takes whatever it produced:
   // a verdict on the check byte, or nothing on every other byte.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (advance) begin
         rsp_valid_in = res_valid;
         rsp_data_in  = result;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      in_byte_ff  <= in_byte_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.checksum_ok    = rsp_data_ff.checksum_ok;
   assign rsp_chan.command_byte   = rsp_data_ff.command_byte;
   assign rsp_chan.measured_value = rsp_data_ff.measured_value;

   // A new verdict can only come from a byte that sat in the input register.
   a_rsp_from_input: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(in_valid_ff))
      else $error("result appeared without a byte in the input register");

   // The input register never drops a byte while the result side is blocked.
   a_input_held: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && !advance) |=> in_valid_ff && $stable(in_byte_ff))
      else $error("buffered byte lost during a result stall");

   // A blocked verdict keeps its payload.
   a_result_held: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> $stable(rsp_data_ff))
      else $error("held result changed before it was taken");

endmodule

// ----- test/tb_sensor_frame_parser_xor_check.sv -----
// Self-checking testbench for the serial frame parser with XOR check byte.
// Depends on sfx_pkg, sfx_req_if, sfx_rsp_if and the sensor_frame_parser_xor_check RTL.
// Drives a directed table of frames, then random framed traffic, under random back-pressure.
module tb_sensor_frame_parser_xor_check;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned FRAME_LEN     = sfx_pkg::FRAME_LEN_DEFAULT;
   localparam int unsigned DIRECTED_ROWS = 26;
   localparam int unsigned RANDOM_ITEMS  = 1200;
   // The sender stops once in the middle of the random traffic and lets the block drain.
   localparam int unsigned DRAIN_AT      = DIRECTED_ROWS + RANDOM_ITEMS / 2;
   // The receiver refuses results for this many cycles once, to fill the block.
   localparam int unsigned LONG_HOLD     = 150;
   localparam int unsigned SETTLE_CYCLES = 8;
   localparam int unsigned CYCLE_LIMIT   = 200000;

   localparam sfx_pkg::result_type NO_VERDICT = '0;

   // One byte of stimulus. Where typed is set, the verdict is written into the table by
   // hand and used in place of the predicted one.
   typedef struct {
      logic [7:0]          rx;
      bit                  typed;
      sfx_pkg::result_type verdict;
   } plan_entry_type;

   typedef enum int unsigned {
      SINK_FREE,
      SINK_LIGHT,
      SINK_HALF,
      SINK_HEAVY
   } sink_mode_type;

   typedef enum int unsigned {
      GEN_NOISE,
      GEN_BAD_HEADER,
      GEN_FRAME
   } traffic_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   sfx_req_if req_chan ();
   sfx_rsp_if rsp_chan ();

   sensor_frame_parser_xor_check #(
      .FRAME_LEN (FRAME_LEN)
   ) uut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always #1 clock = ~clock;

   // Reset is held from the start and then released for good.
   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
   end

   // ---------------------------------------------------------------------------------
   // Frame predictor. It keeps its own copy of the parser state and is stepped once for
   // every byte transaction that the block accepts.
   // ---------------------------------------------------------------------------------
   sfx_pkg::phase_type hunt_phase = sfx_pkg::PH_HUNT;
   logic [6:0]         frame_idx  = '0;
   logic [7:0]         xor_acc    = '0;
   logic [7:0]         cmd_held   = '0;
   logic [31:0]        value_acc  = '0;

   task automatic parse_rx_byte(input logic [7:0] b, output bit emitted,
                                output sfx_pkg::result_type verdict);
      emitted = 1'b0;
      verdict = NO_VERDICT;
      case (hunt_phase)
         sfx_pkg::PH_HUNT: begin
            if (b == sfx_pkg::HDR_FIRST) begin
               xor_acc    = b;
               frame_idx  = 7'd1;
               hunt_phase = sfx_pkg::PH_HDR2;
            end
         end
         sfx_pkg::PH_HDR2: begin
            // A wrong second header byte drops straight back to the hunt; the byte itself
            // is not looked at again as a possible first header byte.
            if (b == sfx_pkg::HDR_SECOND) begin
               xor_acc    = xor_acc ^ b;
               frame_idx  = 7'd2;
               value_acc  = '0;
               hunt_phase = sfx_pkg::PH_BODY;
            end else begin
               hunt_phase = sfx_pkg::PH_HUNT;
               frame_idx  = '0;
               xor_acc    = '0;
            end
         end
         sfx_pkg::PH_BODY: begin
            // Header values inside the body are ordinary data.
            if (frame_idx == sfx_pkg::CMD_INDEX)
               cmd_held = b;
            else if (frame_idx >= sfx_pkg::VALUE_FIRST && frame_idx <= sfx_pkg::VALUE_LAST)
               value_acc = {value_acc[23:0], b};
            xor_acc   = xor_acc ^ b;
            frame_idx = frame_idx + 7'd1;
            if (frame_idx >= 7'(FRAME_LEN - 1))
               hunt_phase = sfx_pkg::PH_CHECK;
         end
         default: begin
            // The check byte always yields a verdict; a failed check reports a zero value.
            emitted                = 1'b1;
            verdict.checksum_ok    = (b == xor_acc);
            verdict.command_byte   = cmd_held;
            verdict.measured_value = (b == xor_acc) ? value_acc : '0;
            hunt_phase = sfx_pkg::PH_HUNT;
            frame_idx  = '0;
            xor_acc    = '0;
         end
      endcase
   endtask

   // ---------------------------------------------------------------------------------
   // Stimulus plan. The directed rows come first; the random traffic is appended to the
   // same queue before reset is released, so the n-th accepted transaction is plan[n].
   // ---------------------------------------------------------------------------------
   plan_entry_type plan [$];

   plan_entry_type directed_rows [DIRECTED_ROWS] = '{
      // Largest positive value with the greatest command byte and a good check byte.
      '{8'hB4, 1'b0, NO_VERDICT}, '{8'h69, 1'b0, NO_VERDICT},
      '{8'hFF, 1'b0, NO_VERDICT}, '{8'h7F, 1'b0, NO_VERDICT},
      '{8'hFF, 1'b0, NO_VERDICT}, '{8'hFF, 1'b0, NO_VERDICT},
      '{8'hFF, 1'b0, NO_VERDICT},
      '{8'hA2, 1'b1, '{1'b1, 8'hFF, 32'sh7FFF_FFFF}},
      // Most negative value with a zero command byte.
      '{8'hB4, 1'b0, NO_VERDICT}, '{8'h69, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, NO_VERDICT}, '{8'h80, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, NO_VERDICT}, '{8'h00, 1'b0, NO_VERDICT},
      '{8'h00, 1'b0, NO_VERDICT},
      '{8'h5D, 1'b1, '{1'b1, 8'h00, 32'sh8000_0000}},
      // A first header byte where the second should be: back to the hunt, no verdict,
      // and the repeated byte must not open a frame of its own.
      '{8'hB4, 1'b0, NO_VERDICT}, '{8'hB4, 1'b0, NO_VERDICT},
      // Header values used as body data, closed by a wrong check byte: the verdict
      // carries the command but the value is forced to zero.
      '{8'hB4, 1'b0, NO_VERDICT}, '{8'h69, 1'b0, NO_VERDICT},
      '{8'hB4, 1'b0, NO_VERDICT}, '{8'h69, 1'b0, NO_VERDICT},
      '{8'h12, 1'b0, NO_VERDICT}, '{8'h34, 1'b0, NO_VERDICT},
      '{8'h56, 1'b0, NO_VERDICT},
      '{8'h8F, 1'b1, '{1'b0, 8'hB4, 32'sh0000_0000}}
   };

   task automatic plan_byte(input logic [7:0] b);
      plan_entry_type e;
      e.rx      = b;
      e.typed   = 1'b0;
      e.verdict = NO_VERDICT;
      plan.push_back(e);
   endtask

   // ---------------------------------------------------------------------------------
   // Checking. Result transactions are compared with the oldest pending verdict before
   // the byte transaction of the same edge is fed to the predictor.
   // ---------------------------------------------------------------------------------
   sfx_pkg::result_type pending_verdicts [$];
   int unsigned fault_count  = 0;
   int unsigned results_seen = 0;
   int unsigned n_accepted   = 0;
   int unsigned cycle_count  = 0;

   always @(posedge clock) begin
      sfx_pkg::result_type want;
      sfx_pkg::result_type predicted;
      plan_entry_type      entry;
      bit                  emitted;
      if (!reset) begin
         if (rsp_chan.valid && rsp_chan.ready) begin
            results_seen++;
            if (pending_verdicts.size() == 0) begin
               $error("result transaction with no verdict pending: ok=%0d cmd=%02h value=%0d",
                      rsp_chan.checksum_ok, rsp_chan.command_byte, rsp_chan.measured_value);
               fault_count++;
            end else begin
               want = pending_verdicts.pop_front();
               if (rsp_chan.checksum_ok !== want.checksum_ok) begin
                  $error("checksum_ok: expected %0d, got %0d",
                         want.checksum_ok, rsp_chan.checksum_ok);
                  fault_count++;
               end
               if (rsp_chan.command_byte !== want.command_byte) begin
                  $error("command_byte: expected %02h, got %02h",
                         want.command_byte, rsp_chan.command_byte);
                  fault_count++;
               end
               if (rsp_chan.measured_value !== want.measured_value) begin
                  $error("measured_value: expected %0d, got %0d",
                         want.measured_value, rsp_chan.measured_value);
                  fault_count++;
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            entry = plan[n_accepted];
            n_accepted++;
            parse_rx_byte(entry.rx, emitted, predicted);
            if (entry.typed)
               pending_verdicts.push_back(entry.verdict);
            else if (emitted)
               pending_verdicts.push_back(predicted);
         end
      end
   end

   // Watchdog: a run that hangs is reported as a failure.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count == CYCLE_LIMIT) begin
         $display("FAIL sensor_frame_parser_xor_check");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------------
   // Receiver. It switches between stretches of free flow and stretches of random
   // stalls, and once, after a couple of dozen results, refuses everything for a long
   // stretch so that the block fills up and has to stall its input.
   // ---------------------------------------------------------------------------------
   initial begin : result_sink
      int unsigned   span;
      sink_mode_type mode;
      bit            held_off;
      held_off = 1'b0;
      rsp_chan.ready <= 1'b0;
      while (reset) @(posedge clock);
      forever begin
         if (!held_off && results_seen >= 25) begin
            held_off = 1'b1;
            repeat (LONG_HOLD) begin
               @(posedge clock);
               rsp_chan.ready <= 1'b0;
            end
         end
         mode = sink_mode_type'($urandom_range(0, 3));
         span = $urandom_range(4, 40);
         repeat (span) begin
            @(posedge clock);
            case (mode)
               SINK_FREE:  rsp_chan.ready <= 1'b1;
               SINK_LIGHT: rsp_chan.ready <= ($urandom_range(0, 3) != 0);
               SINK_HALF:  rsp_chan.ready <= ($urandom_range(0, 1) != 0);
               default:    rsp_chan.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------------
   // Sender. It builds the plan, then offers bytes in bursts of random length separated
   // by random gaps (some bursts run straight into the next). It drains the block after
   // the directed part and once in the middle of the random traffic, and at the end
   // waits for every pending verdict before giving the final word.
   // ---------------------------------------------------------------------------------
   initial begin : byte_source
      int unsigned      burst;
      int unsigned      gap;
      int unsigned      sent;
      int unsigned      k;
      int unsigned      n;
      logic [7:0]       b;
      logic [7:0]       sum;
      traffic_kind_type kind;

      req_chan.valid   <= 1'b0;
      req_chan.rx_byte <= '0;

      foreach (directed_rows[i])
         plan.push_back(directed_rows[i]);

      // Mostly well-formed frames with random content, some with a corrupted check
      // byte, mixed with line noise and broken headers.
      while (plan.size() < DIRECTED_ROWS + RANDOM_ITEMS) begin
         n = $urandom_range(0, 9);
         kind = (n == 0) ? GEN_NOISE : (n == 1) ? GEN_BAD_HEADER : GEN_FRAME;
         case (kind)
            GEN_NOISE: begin
               repeat ($urandom_range(1, 4))
                  plan_byte(8'($urandom));
            end
            GEN_BAD_HEADER: begin
               b = 8'($urandom);
               if (b == sfx_pkg::HDR_SECOND)
                  b = sfx_pkg::HDR_FIRST;
               plan_byte(sfx_pkg::HDR_FIRST);
               plan_byte(b);
            end
            default: begin
               sum = sfx_pkg::HDR_FIRST ^ sfx_pkg::HDR_SECOND;
               plan_byte(sfx_pkg::HDR_FIRST);
               plan_byte(sfx_pkg::HDR_SECOND);
               for (k = 2; k < FRAME_LEN - 1; k++) begin
                  case ($urandom_range(0, 7))
                     0:       b = 8'h00;
                     1:       b = 8'hFF;
                     2:       b = 8'h80;
                     3:       b = 8'h7F;
                     default: b = 8'($urandom);
                  endcase
                  sum = sum ^ b;
                  plan_byte(b);
               end
               if ($urandom_range(0, 4) == 0)
                  sum = sum ^ 8'($urandom_range(1, 255));
               plan_byte(sum);
            end
         endcase
      end

      while (reset) @(posedge clock);

      sent = 0;
      while (sent < plan.size()) begin
         burst = $urandom_range(1, 24);
         while (burst > 0 && sent < plan.size()) begin
            req_chan.valid   <= 1'b1;
            req_chan.rx_byte <= plan[sent].rx;
            do @(posedge clock); while (!req_chan.ready);
            sent++;
            burst--;
            if (sent == DIRECTED_ROWS || sent == DRAIN_AT) begin
               // Hold back until every verdict owed so far has been delivered.
               req_chan.valid <= 1'b0;
               do @(posedge clock); while (pending_verdicts.size() != 0);
            end
         end
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap != 0 && sent < plan.size()) begin
            req_chan.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      req_chan.valid <= 1'b0;

      // Step past the edge of the last transaction so that its verdict is already queued.
      do @(posedge clock); while (pending_verdicts.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);

      if (fault_count == 0 && pending_verdicts.size() == 0)
         $display("PASS sensor_frame_parser_xor_check");
      else
         $display("FAIL sensor_frame_parser_xor_check");
      $finish;
   end

endmodule

// ----- files.f -----
rtl/core/sfx_pkg.sv
rtl/core/sfx_req_if.sv
rtl/core/sfx_rsp_if.sv
rtl/core/sfx_parse.sv
rtl/core/sensor_frame_parser_xor_check.sv
test/tb_sensor_frame_parser_xor_check.sv
